FILE: design/tdt_pkg.sv
package tdt_pkg;

    // Action codes carried by a sample request.
    typedef enum logic [1:0] {
        ACT_SAMPLE    = 2'd0,
        ACT_FORGET    = 2'd1,
        ACT_RESET_ALL = 2'd2,
        ACT_IGNORE    = 2'd3
    } action_t;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_CLICK_RADIUS_SQ     = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_DOUBLE_CLICK_WINDOW = 1'b1;

    // Configuration reset values: 0.005 screen squared and 300 ms.
    localparam logic [31:0] CLICK_RADIUS_SQ_RESET     = 32'd21474836;
    localparam logic [15:0] DOUBLE_CLICK_WINDOW_RESET = 16'd300;

    typedef struct packed {
        action_t            action;
        logic [2:0]         pointer;
        logic               is_touching;
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic [31:0]        time_ms;
    } tdt_in_t;

    typedef struct packed {
        logic [2:0]         out_pointer;
        logic               now_touching;
        logic               before_touching;
        logic               click;
        logic               double_click;
        logic signed [15:0] touch_x;
        logic signed [15:0] touch_y;
    } tdt_out_t;

    // Settings handed from the configuration registers to the tracker.
    typedef struct packed {
        logic [31:0] click_radius_sq;
        logic [15:0] double_click_window;
    } tdt_cfg_t;

endpackage

FILE: design/tap_double_tap_detector.sv
// A request is held in the input register, then moved to the result register when that frees.
// Throughput: one request per cycle unless the result stalls; the per-pointer update
// finishes in the processing cycle. The rate is set by the single pass from the input
// register through the distance multipliers to the result register and the pointer state.
// Reset clears the touch flags, seen bits, tap positions and times and restores both settings.
module tap_double_tap_detector #(
    parameter int TOUCH_POINTS = 8
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          sample_valid,
    output logic                          sample_ready,
    input  tdt_pkg::tdt_in_t              sample,
    output logic                          result_valid,
    input  logic                          result_ready,
    output tdt_pkg::tdt_out_t             result,
    input  logic                          cfg_write_en,
    input  logic [tdt_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]                   cfg_data
);
    import tdt_pkg::*;

    logic      stage_valid_reg;
    logic      stage_valid_next;
    tdt_in_t   stage_item_reg;
    logic      result_valid_reg;
    logic      result_valid_next;
    tdt_out_t  result_reg;
    tdt_out_t  tracker_result;
    tdt_cfg_t  cfg_reg;
    logic      out_free;
    logic      advance;
    logic      take;

    // Pipeline handshake: the input stage moves on whenever the result slot frees.
    assign out_free     = !result_valid_reg || result_ready;
    assign advance      = stage_valid_reg && out_free;
    assign sample_ready = !stage_valid_reg || out_free;
    assign take         = sample_valid && sample_ready;

    assign stage_valid_next  = take || (stage_valid_reg && !advance);
    assign result_valid_next = advance || (result_valid_reg && !result_ready);

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.click_radius_sq     <= CLICK_RADIUS_SQ_RESET;
            cfg_reg.double_click_window <= DOUBLE_CLICK_WINDOW_RESET;
        end
        else if (cfg_write_en)
        begin
            unique case (cfg_index)
                CFG_CLICK_RADIUS_SQ:     cfg_reg.click_radius_sq     <= cfg_data;
                CFG_DOUBLE_CLICK_WINDOW: cfg_reg.double_click_window <= cfg_data[15:0];
                default:                 cfg_reg <= cfg_reg;
            endcase
        end
    end

    // Valid flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg  <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            stage_valid_reg  <= stage_valid_next;
            result_valid_reg <= result_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            stage_item_reg <= sample;
        end
        if (advance)
        begin
            result_reg <= tracker_result;
        end
    end

    // Per-pointer tracking and tap decisions.
    tdt_tracker #(
        .TOUCH_POINTS (TOUCH_POINTS)
    ) u_tracker (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (advance),
        .item   (stage_item_reg),
        .cfg    (cfg_reg),
        .result (tracker_result)
    );

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

FILE: design/tdt_dist_cmp.sv
module tdt_dist_cmp (
    input  logic signed [15:0] ax,
    input  logic signed [15:0] ay,
    input  logic signed [15:0] bx,
    input  logic signed [15:0] by,
    input  logic [31:0]        radius_sq,
    output logic               inside_radius
);

    logic signed [16:0] dx;
    logic signed [16:0] dy;
    logic signed [33:0] dx_sq;
    logic signed [33:0] dy_sq;
    logic [33:0]        dist_sq;

    // Coordinate differences need one extra bit.
    assign dx = {ax[15], ax} - {bx[15], bx};
    assign dy = {ay[15], ay} - {by[15], by};

    // Each square is at most 2^32, so the sum fits in 34 unsigned bits.
    assign dx_sq   = 34'(dx) * 34'(dx);
    assign dy_sq   = 34'(dy) * 34'(dy);
    assign dist_sq = $unsigned(dx_sq) + $unsigned(dy_sq);

    assign inside_radius = dist_sq < {2'b00, radius_sq};

endmodule

FILE: design/tdt_tracker.sv
module tdt_tracker #(
    parameter int TOUCH_POINTS = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             fire,
    input  tdt_pkg::tdt_in_t item,
    input  tdt_pkg::tdt_cfg_t cfg,
    output tdt_pkg::tdt_out_t result
);
    import tdt_pkg::*;

    localparam int IDX_W = (TOUCH_POINTS > 1) ? $clog2(TOUCH_POINTS) : 1;
    localparam logic [4:0] NUM_POINTS = 5'(TOUCH_POINTS);

    // Per-pointer state.
    logic               down_reg     [TOUCH_POINTS];
    logic               seen_reg     [TOUCH_POINTS];
    logic signed [15:0] press_x_reg  [TOUCH_POINTS];
    logic signed [15:0] press_y_reg  [TOUCH_POINTS];
    logic signed [15:0] recent_x_reg [TOUCH_POINTS];
    logic signed [15:0] recent_y_reg [TOUCH_POINTS];
    logic signed [15:0] tap_x_reg    [TOUCH_POINTS];
    logic signed [15:0] tap_y_reg    [TOUCH_POINTS];
    logic [31:0]        tap_time_reg [TOUCH_POINTS];

    logic               in_range;
    logic [IDX_W-1:0]   idx;
    logic               was_down;
    logic               seen;
    logic signed [15:0] recent_x;
    logic signed [15:0] recent_y;
    logic [31:0]        gap;
    logic               press_near;
    logic               tap_near;
    logic               is_sample;
    logic               release_evt;
    logic               click;
    logic               dbl;
    logic               now_touching;
    logic               do_update;

    // Select the addressed pointer.
    assign in_range = {2'b00, item.pointer} < NUM_POINTS;
    assign idx      = IDX_W'(item.pointer);
    assign was_down = down_reg[idx];
    assign seen     = seen_reg[idx];
    assign recent_x = recent_x_reg[idx];
    assign recent_y = recent_y_reg[idx];

    // Release-to-press distance and distance to the previous tap.
    tdt_dist_cmp u_press_cmp (
        .ax            (recent_x),
        .ay            (recent_y),
        .bx            (press_x_reg[idx]),
        .by            (press_y_reg[idx]),
        .radius_sq     (cfg.click_radius_sq),
        .inside_radius (press_near)
    );

    tdt_dist_cmp u_tap_cmp (
        .ax            (recent_x),
        .ay            (recent_y),
        .bx            (tap_x_reg[idx]),
        .by            (tap_y_reg[idx]),
        .radius_sq     (cfg.click_radius_sq),
        .inside_radius (tap_near)
    );

    // Tap and double-tap decisions; the time gap wraps.
    assign is_sample   = item.action == ACT_SAMPLE;
    assign release_evt = is_sample && !item.is_touching && was_down;
    assign click       = release_evt && press_near;
    assign gap         = item.time_ms - tap_time_reg[idx];
    assign dbl         = click && (gap < {16'd0, cfg.double_click_window}) && tap_near;
    assign do_update   = fire && in_range;

    // Touch flag after this step.
    always_comb
    begin
        unique case (item.action)
            ACT_SAMPLE:    now_touching = item.is_touching;
            ACT_RESET_ALL: now_touching = 1'b0;
            ACT_FORGET:    now_touching = was_down;
            ACT_IGNORE:    now_touching = was_down;
            default:       now_touching = was_down;
        endcase
    end

    // Result for the addressed pointer.
    always_comb
    begin
        result             = '0;
        result.out_pointer = item.pointer;
        if (in_range)
        begin
            result.now_touching    = now_touching;
            result.before_touching = is_sample ? was_down : now_touching;
            result.click           = click;
            result.double_click    = dbl;
            if (is_sample && item.is_touching)
            begin
                result.touch_x = item.pos_x;
                result.touch_y = item.pos_y;
            end
            else if (seen)
            begin
                result.touch_x = recent_x;
                result.touch_y = recent_y;
            end
        end
    end

    // Control state and tap history, cleared by reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < TOUCH_POINTS; i++)
            begin
                down_reg[i]     <= 1'b0;
                seen_reg[i]     <= 1'b0;
                tap_x_reg[i]    <= '0;
                tap_y_reg[i]    <= '0;
                tap_time_reg[i] <= '0;
            end
        end
        else if (do_update)
        begin
            unique case (item.action)
                ACT_SAMPLE:
                begin
                    down_reg[idx] <= item.is_touching;
                    if (item.is_touching)
                    begin
                        seen_reg[idx] <= 1'b1;
                    end
                    if (click)
                    begin
                        tap_time_reg[idx] <= item.time_ms;
                        if (!dbl)
                        begin
                            tap_x_reg[idx] <= recent_x;
                            tap_y_reg[idx] <= recent_y;
                        end
                    end
                end
                ACT_FORGET:
                begin
                    tap_time_reg[idx] <= '0;
                end
                ACT_RESET_ALL:
                begin
                    for (int i = 0; i < TOUCH_POINTS; i++)
                    begin
                        down_reg[i]     <= 1'b0;
                        tap_time_reg[i] <= '0;
                    end
                end
                ACT_IGNORE:
                begin
                end
                default:
                begin
                end
            endcase
        end
    end

    // Positions, read only after they were written.
    always_ff @(posedge clk)
    begin
        if (do_update && is_sample && item.is_touching)
        begin
            recent_x_reg[idx] <= item.pos_x;
            recent_y_reg[idx] <= item.pos_y;
            if (!was_down)
            begin
                press_x_reg[idx] <= item.pos_x;
                press_y_reg[idx] <= item.pos_y;
            end
        end
    end

endmodule
